/* rtl/mmae_pkg.sv */
// Package with the types, codes and helper functions of the matrix multiply-add engine.
`default_nettype none

package mmae_pkg;

    // Field and port widths
    localparam int IDX_W      = 3;
    localparam int DIM_W      = 4;
    localparam int DATA_W     = 32;
    localparam int ACC_W      = 52;
    localparam int PROD_W     = 64;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;

    typedef logic [1:0]              mode_t;
    typedef logic [1:0]              req_t;
    typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;
    typedef logic [DIM_W-1:0]        dim_t;
    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    // Operating modes
    localparam mode_t MODE_ADD     = 2'd0;
    localparam mode_t MODE_MUL     = 2'd1;
    localparam mode_t MODE_MUL_ADD = 2'd2;

    // Request kinds carried on the input tuser
    localparam req_t REQ_LOAD_A = 2'd0;
    localparam req_t REQ_LOAD_B = 2'd1;
    localparam req_t REQ_LOAD_C = 2'd2;
    localparam req_t REQ_START  = 2'd3;

    // Configuration register indexes
    localparam cfg_idx_t REG_MODE   = 3'd0;
    localparam cfg_idx_t REG_ROWS_A = 3'd1;
    localparam cfg_idx_t REG_COLS_A = 3'd2;
    localparam cfg_idx_t REG_ROWS_B = 3'd3;
    localparam cfg_idx_t REG_COLS_B = 3'd4;
    localparam cfg_idx_t REG_ROWS_C = 3'd5;
    localparam cfg_idx_t REG_COLS_C = 3'd6;

    // Result status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_DIM_ERR = 1'b1;

    // Clamp the wide accumulator to the signed 32-bit range.
    function automatic word_t sat32(input acc_t v);
        word_t r;
        if (&v[ACC_W-1:DATA_W-1] || ~|v[ACC_W-1:DATA_W-1]) begin
            r = v[DATA_W-1:0];
        end
        else if (v[ACC_W-1]) begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/matrix_multiply_add_engine_core.sv */
// Matrix multiply-add engine: element stores in three memories and a multiply-accumulate pipeline.
// A load is written into its store as it is accepted; a start with bad dimensions gives its error
// item in the next cycle. A run gives its result items in row-major order, one element at a time,
// from the single read port of each store, which feeds one multiply-accumulate step per cycle.
// Loads are taken every cycle while no run is active and the output register is free.
// Reset clears control state and the configuration to mode 1 with all dimensions 8; stores keep junk.
`default_nettype none

module matrix_multiply_add_engine_core
    import mmae_pkg::*;
#(
    parameter int MAX_DIM = 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // Input items
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,  // row_index, col_index, elem_value, zero pad
    input  wire logic [1:0]            s_axis_tuser,  // req_type
    // Result items
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]       m_axis_tdata,  // out_row, out_col, out_value, zero pad
    output logic                       m_axis_tuser,  // status
    output logic                       m_axis_tlast   // last
);

    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MEM_DEPTH = (DEPTH > 1) ? DEPTH : 2;

    typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_DRAIN} state_t;

    // Flat store address of a row and column.
    function automatic logic [AW-1:0] elem_addr(input idx_t r, input idx_t c);
        return AW'(int'(r) * MAX_DIM + int'(c));
    endfunction

    // A dimension is usable when it lies in 1..MAX_DIM.
    function automatic logic dim_ok(input dim_t d);
        return (d != '0) && (d <= DIM_W'(MAX_DIM));
    endfunction

    // Element stores
    word_t mem_a [MEM_DEPTH];
    word_t mem_b [MEM_DEPTH];
    word_t mem_c [MEM_DEPTH];

    // Configuration registers
    mode_t mode_reg;
    dim_t  rows_a_reg, cols_a_reg, rows_b_reg, cols_b_reg, rows_c_reg, cols_c_reg;

    // Run control
    state_t state_reg, state_next;
    mode_t  run_mode_reg;
    dim_t   nr_reg, nc_reg, nk_reg;
    idx_t   i_reg, j_reg, k_reg;

    // Pipeline control flags
    logic rd_vld_reg, rd_first_reg, rd_last_reg;
    logic tm_vld_reg, tm_first_reg, tm_last_reg;
    logic acc_done_reg;

    // Pipeline payload
    word_t rd_a_reg, rd_b_reg, rd_c_reg;
    acc_t  term_reg, base_reg, acc_reg;

    // Output register
    logic              out_valid_reg;
    idx_t              out_row_reg, out_col_reg;
    word_t             out_value_reg;
    logic              out_status_reg, out_last_reg;

    // Input fields
    idx_t  in_row, in_col;
    word_t in_value;
    req_t  in_req;
    logic  in_accept, out_free, load_ok, start_ok, emit_elem, last_k, last_j, last_i;
    logic [AW-1:0] addr_a, addr_b, addr_c;
    logic signed [PROD_W-1:0] prod;
    logic signed [DATA_W:0]   sum_ab;

    assign in_row   = s_axis_tdata[2:0];
    assign in_col   = s_axis_tdata[5:3];
    assign in_value = s_axis_tdata[37:6];
    assign in_req   = s_axis_tuser;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign load_ok       = ({1'b0, in_row} < DIM_W'(MAX_DIM))
                        && ({1'b0, in_col} < DIM_W'(MAX_DIM));

    // Dimension check for a start, by mode
    always_comb
    begin
        unique case (mode_reg)
            MODE_ADD:
                start_ok = dim_ok(rows_a_reg) && dim_ok(cols_a_reg)
                        && rows_a_reg == rows_b_reg && cols_a_reg == cols_b_reg;
            MODE_MUL:
                start_ok = dim_ok(rows_a_reg) && dim_ok(cols_a_reg) && dim_ok(cols_b_reg)
                        && cols_a_reg == rows_b_reg;
            MODE_MUL_ADD:
                start_ok = dim_ok(rows_a_reg) && dim_ok(cols_a_reg) && dim_ok(cols_b_reg)
                        && cols_a_reg == rows_b_reg
                        && rows_c_reg == rows_a_reg && cols_c_reg == cols_b_reg;
            default:
                start_ok = 1'b0;
        endcase
    end

    // Read addresses of the current step
    always_comb
    begin
        addr_c = elem_addr(i_reg, j_reg);
        if (run_mode_reg == MODE_ADD)
        begin
            addr_a = elem_addr(i_reg, j_reg);
            addr_b = elem_addr(i_reg, j_reg);
        end
        else
        begin
            addr_a = elem_addr(i_reg, k_reg);
            addr_b = elem_addr(k_reg, j_reg);
        end
    end

    assign last_k    = ({1'b0, k_reg} + DIM_W'(1)) == nk_reg;
    assign last_j    = ({1'b0, j_reg} + DIM_W'(1)) == nc_reg;
    assign last_i    = ({1'b0, i_reg} + DIM_W'(1)) == nr_reg;
    assign emit_elem = (state_reg == ST_DRAIN) && acc_done_reg && out_free;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_accept && in_req == REQ_START && start_ok)
                begin
                    state_next = ST_ISSUE;
                end
            ST_ISSUE:
                if (last_k)
                begin
                    state_next = ST_DRAIN;
                end
            ST_DRAIN:
                if (emit_elem)
                begin
                    state_next = (last_i && last_j) ? ST_IDLE : ST_ISSUE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Store writes on loads
    always_ff @(posedge clk)
    begin
        if (in_accept && load_ok)
        begin
            if (in_req == REQ_LOAD_A)
            begin
                mem_a[elem_addr(in_row, in_col)] <= in_value;
            end
            if (in_req == REQ_LOAD_B)
            begin
                mem_b[elem_addr(in_row, in_col)] <= in_value;
            end
            if (in_req == REQ_LOAD_C)
            begin
                mem_c[elem_addr(in_row, in_col)] <= in_value;
            end
        end
    end

    // Registered store reads
    always_ff @(posedge clk)
    begin
        rd_a_reg <= mem_a[addr_a];
        rd_b_reg <= mem_b[addr_b];
        rd_c_reg <= mem_c[addr_c];
    end

    // Product or sum of the read pair; the product is floored back to Q16.16
    assign prod   = $signed(rd_a_reg) * $signed(rd_b_reg);
    assign sum_ab = {rd_a_reg[DATA_W-1], rd_a_reg} + {rd_b_reg[DATA_W-1], rd_b_reg};

    always_ff @(posedge clk)
    begin
        if (run_mode_reg == MODE_ADD)
        begin
            term_reg <= {{(ACC_W-DATA_W-1){sum_ab[DATA_W]}}, sum_ab};
        end
        else
        begin
            term_reg <= {{(ACC_W-PROD_W+FRAC_W){prod[PROD_W-1]}}, prod[PROD_W-1:FRAC_W]};
        end
        if (rd_first_reg)
        begin
            base_reg <= (run_mode_reg == MODE_MUL_ADD)
                      ? {{(ACC_W-DATA_W){rd_c_reg[DATA_W-1]}}, rd_c_reg} : '0;
        end
        if (tm_vld_reg)
        begin
            acc_reg <= (tm_first_reg ? base_reg : acc_reg) + term_reg;
        end
    end

    // Control state, configuration, counters and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_MUL;
            rows_a_reg     <= DIM_W'(8);
            cols_a_reg     <= DIM_W'(8);
            rows_b_reg     <= DIM_W'(8);
            cols_b_reg     <= DIM_W'(8);
            rows_c_reg     <= DIM_W'(8);
            cols_c_reg     <= DIM_W'(8);
            run_mode_reg   <= MODE_MUL;
            nr_reg         <= '0;
            nc_reg         <= '0;
            nk_reg         <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            rd_vld_reg     <= 1'b0;
            rd_first_reg   <= 1'b0;
            rd_last_reg    <= 1'b0;
            tm_vld_reg     <= 1'b0;
            tm_first_reg   <= 1'b0;
            tm_last_reg    <= 1'b0;
            acc_done_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
            out_value_reg  <= '0;
            out_status_reg <= STATUS_OK;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Configuration writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MODE:   mode_reg   <= cfg_data[1:0];
                    REG_ROWS_A: rows_a_reg <= cfg_data;
                    REG_COLS_A: cols_a_reg <= cfg_data;
                    REG_ROWS_B: rows_b_reg <= cfg_data;
                    REG_COLS_B: cols_b_reg <= cfg_data;
                    REG_ROWS_C: rows_c_reg <= cfg_data;
                    REG_COLS_C: cols_c_reg <= cfg_data;
                    default: ;
                endcase
            end

            // Latch run geometry on a good start
            if (state_reg == ST_IDLE && in_accept && in_req == REQ_START && start_ok)
            begin
                run_mode_reg <= mode_reg;
                nr_reg       <= rows_a_reg;
                nc_reg       <= (mode_reg == MODE_ADD) ? cols_a_reg : cols_b_reg;
                nk_reg       <= (mode_reg == MODE_ADD) ? DIM_W'(1) : cols_a_reg;
                i_reg        <= '0;
                j_reg        <= '0;
                k_reg        <= '0;
            end

            // Issue one read step per cycle
            rd_vld_reg   <= (state_reg == ST_ISSUE);
            rd_first_reg <= (state_reg == ST_ISSUE) && (k_reg == '0);
            rd_last_reg  <= (state_reg == ST_ISSUE) && last_k;
            if (state_reg == ST_ISSUE)
            begin
                k_reg <= last_k ? '0 : k_reg + IDX_W'(1);
            end

            tm_vld_reg   <= rd_vld_reg;
            tm_first_reg <= rd_first_reg;
            tm_last_reg  <= rd_last_reg;

            // Element finished when its last term is accumulated
            if (tm_vld_reg && tm_last_reg)
            begin
                acc_done_reg <= 1'b1;
            end
            else if (emit_elem)
            begin
                acc_done_reg <= 1'b0;
            end

            // Step to the next element in row-major order
            if (emit_elem)
            begin
                if (last_j)
                begin
                    j_reg <= '0;
                    if (!last_i)
                    begin
                        i_reg <= i_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    j_reg <= j_reg + IDX_W'(1);
                end
            end

            // Output payload: an error item for a bad start, else the finished element
            if (in_accept && in_req == REQ_START && !start_ok)
            begin
                out_row_reg    <= '0;
                out_col_reg    <= '0;
                out_value_reg  <= '0;
                out_status_reg <= STATUS_DIM_ERR;
                out_last_reg   <= 1'b1;
            end
            else if (emit_elem)
            begin
                out_row_reg    <= i_reg;
                out_col_reg    <= j_reg;
                out_value_reg  <= sat32(acc_reg);
                out_status_reg <= STATUS_OK;
                out_last_reg   <= last_i && last_j;
            end

            // Output valid
            if (emit_elem || (in_accept && in_req == REQ_START && !start_ok))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_value_reg, out_col_reg, out_row_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire
